FILE: rtl/core/spm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants, types and the quarter-sine gain table of the spread mixer.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int MAX_CHANNELS  = 16;
    localparam int CH_W          = $clog2(MAX_CHANNELS);
    localparam int NCH_W         = 5;
    localparam int POS_W         = 11;
    localparam int SAMPLE_BITS   = 24;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = GAIN_BITS - 1;
    localparam int PROD_W        = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_W         = 64;
    localparam int TBL_SEGS      = 16;
    localparam int SEG_W         = 5;
    localparam int STEP_W        = 12;
    localparam int FRAC_W        = 11;
    localparam int IPROD_W       = STEP_W + FRAC_W;
    localparam int NUM_W         = 18;
    localparam int DEN_W         = 15;
    localparam int FAC_W         = 13;
    localparam int DIV_W         = 16;
    localparam int DIVR_W        = 5;
    localparam int DIV_CNT_W     = $clog2(DIV_W);
    localparam int GAIN_ZERO_MAX = (1 << (GAIN_BITS - 1)) / 10000;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CHANNELS = 4'd0,
        REG_CENTER       = 4'd1,
        REG_SPREAD       = 4'd2,
        REG_COMPENSATE   = 4'd3
    } t_cfg_reg;

    // configuration after range clamping
    typedef struct packed {
        logic [NCH_W-1:0]        n;
        logic [CH_W-1:0]         m;      // n - 1
        logic signed [POS_W-1:0] ctr;
        logic [POS_W-1:0]        spr;
        logic                    comp;
    } t_cfg;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gl;
        logic [GAIN_BITS-1:0] gr;
    } t_gain_pair;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        t_gain_pair      gains;
    } t_gain_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_CLIP,
        S_SEG_WAIT,
        S_MUL_R,
        S_QR_GO,
        S_QR_WAIT,
        S_MUL_L,
        S_QL_GO,
        S_QL_WAIT,
        S_CR_GO,
        S_CR_WAIT,
        S_CL_GO,
        S_CL_WAIT,
        S_WRITE
    } t_gc_state;

    typedef enum logic [1:0] {
        MX_IDLE,
        MX_MUL,
        MX_ACC,
        MX_OUT
    } t_mix_state;

    // sin(pi/2 * seg/16) in Q1.15
    function automatic logic [GAIN_BITS-1:0] sine_q15(input logic [SEG_W-1:0] seg);
        logic [GAIN_BITS-1:0] v;
        case (seg)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12540;
            5'd5:    v = 16'd15447;
            5'd6:    v = 16'd18205;
            5'd7:    v = 16'd20788;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25330;
            5'd10:   v = 16'd27246;
            5'd11:   v = 16'd28899;
            5'd12:   v = 16'd30274;
            5'd13:   v = 16'd31357;
            5'd14:   v = 16'd32138;
            5'd15:   v = 16'd32610;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

    // table slope of one segment, zero past the end
    function automatic logic [STEP_W-1:0] sine_step(input logic [SEG_W-1:0] seg);
        logic [GAIN_BITS-1:0] d;
        if (seg >= SEG_W'(TBL_SEGS)) begin
            d = '0;
        end else begin
            d = sine_q15(seg + 5'd1) - sine_q15(seg);
        end
        return d[STEP_W-1:0];
    endfunction

endpackage

FILE: rtl/core/spm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_div
// Restoring divider, one quotient bit per cycle. Small divisor (up to 16).
// ----------------------------------------------------------------------------
module spm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_abort,
    input  logic                             i_start,
    input  logic [spm_pkg::DIV_W-1:0]        i_dividend,
    input  logic [spm_pkg::DIVR_W-1:0]       i_divisor,
    output logic                             o_done,
    output logic [spm_pkg::DIV_W-1:0]        o_quot,
    output logic [spm_pkg::DIVR_W-1:0]       o_rem
);

    logic                            r_busy;
    logic                            r_done;
    logic [spm_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [spm_pkg::DIV_W-1:0]       r_quo;
    logic [spm_pkg::DIVR_W-1:0]      r_rem;
    logic [spm_pkg::DIVR_W-1:0]      r_dvs;

    logic [spm_pkg::DIVR_W:0]        sh;
    logic [spm_pkg::DIVR_W:0]        dvs_x;
    logic                            fits;
    logic [spm_pkg::DIVR_W:0]        n_rem_x;

    always_comb begin
        sh      = {r_rem, r_quo[spm_pkg::DIV_W-1]};
        dvs_x   = {1'b0, r_dvs};
        fits    = (sh >= dvs_x);
        n_rem_x = fits ? (sh - dvs_x) : sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_abort) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == spm_pkg::DIV_CNT_W'(spm_pkg::DIV_W - 1));
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == spm_pkg::DIV_CNT_W'(spm_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[spm_pkg::DIV_W-2:0], fits};
            r_rem <= n_rem_x[spm_pkg::DIVR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/spm_gain_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_gain_calc
// Sweeps the active channels and computes their left/right pan gains into
// the gain memory. Positions step by 2*spread per channel; all divisions by
// the channel count go through one shared serial divider.
// ----------------------------------------------------------------------------
module spm_gain_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_restart,
    input  spm_pkg::t_cfg      i_cfg,
    output spm_pkg::t_gain_wr  o_wr,
    output logic               o_busy
);

    spm_pkg::t_gc_state r_state;
    spm_pkg::t_gc_state n_state;

    logic [spm_pkg::CH_W-1:0]           r_ch;
    logic signed [spm_pkg::NUM_W-1:0]   r_num;
    logic [spm_pkg::DEN_W-1:0]          r_numc;
    logic [spm_pkg::SEG_W-1:0]          r_seg_r;
    logic [spm_pkg::SEG_W-1:0]          r_seg_l;
    logic [spm_pkg::FRAC_W-1:0]         r_rr;
    logic [spm_pkg::FRAC_W-1:0]         r_rl;
    logic [spm_pkg::IPROD_W-1:0]        r_prod;
    logic [spm_pkg::GAIN_BITS-1:0]      r_g_r;
    logic [spm_pkg::GAIN_BITS-1:0]      r_g_l;

    logic                               div_start;
    logic [spm_pkg::DIV_W-1:0]          div_dividend;
    logic [spm_pkg::DIVR_W-1:0]         div_divisor;
    logic                               div_done;
    logic [spm_pkg::DIV_W-1:0]          div_quot;
    logic [spm_pkg::DIVR_W-1:0]         div_rem;

    logic signed [spm_pkg::FAC_W-1:0]   fac;
    logic signed [spm_pkg::NUM_W-1:0]   base;
    logic [spm_pkg::DEN_W-1:0]          den;
    logic [spm_pkg::DEN_W-1:0]          numc_c;
    logic [spm_pkg::FRAC_W-1:0]         rr_c;
    logic [spm_pkg::FRAC_W-1:0]         span_c;
    logic [spm_pkg::IPROD_W-1:0]        y_c;

    spm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_abort    (i_restart),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // position numerator of channel 0: (n-1)*(2*(c+512) - spread)
    always_comb begin
        fac  = (spm_pkg::FAC_W'(i_cfg.ctr) <<< 1) + spm_pkg::FAC_W'(1024)
             - $signed({2'b00, i_cfg.spr});
        base = spm_pkg::NUM_W'(fac * $signed({1'b0, i_cfg.m}));
        den  = {i_cfg.m, 11'b0};
        if (r_num < 0) begin
            numc_c = '0;
        end else if (r_num > $signed({3'b000, den})) begin
            numc_c = den;
        end else begin
            numc_c = r_num[spm_pkg::DEN_W-1:0];
        end
        // remainder of num mod 128*(n-1): divider remainder above the low 7 bits
        rr_c   = {div_rem[spm_pkg::CH_W-1:0], r_numc[6:0]};
        span_c = {i_cfg.m, 7'b0};
        // round half up: + 64*(n-1) before dividing by 128*(n-1)
        y_c    = r_prod + spm_pkg::IPROD_W'({i_cfg.m, 6'b0});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            spm_pkg::S_IDLE:     n_state = spm_pkg::S_IDLE;
            spm_pkg::S_BASE:     n_state = spm_pkg::S_CLIP;
            spm_pkg::S_CLIP:     n_state = spm_pkg::S_SEG_WAIT;
            spm_pkg::S_SEG_WAIT: if (div_done) n_state = spm_pkg::S_MUL_R;
            spm_pkg::S_MUL_R:    n_state = spm_pkg::S_QR_GO;
            spm_pkg::S_QR_GO:    n_state = spm_pkg::S_QR_WAIT;
            spm_pkg::S_QR_WAIT:  if (div_done) n_state = spm_pkg::S_MUL_L;
            spm_pkg::S_MUL_L:    n_state = spm_pkg::S_QL_GO;
            spm_pkg::S_QL_GO:    n_state = spm_pkg::S_QL_WAIT;
            spm_pkg::S_QL_WAIT: begin
                if (div_done) begin
                    n_state = i_cfg.comp ? spm_pkg::S_CR_GO : spm_pkg::S_WRITE;
                end
            end
            spm_pkg::S_CR_GO:    n_state = spm_pkg::S_CR_WAIT;
            spm_pkg::S_CR_WAIT:  if (div_done) n_state = spm_pkg::S_CL_GO;
            spm_pkg::S_CL_GO:    n_state = spm_pkg::S_CL_WAIT;
            spm_pkg::S_CL_WAIT:  if (div_done) n_state = spm_pkg::S_WRITE;
            spm_pkg::S_WRITE: begin
                n_state = (r_ch == i_cfg.m) ? spm_pkg::S_IDLE : spm_pkg::S_CLIP;
            end
            default:             n_state = spm_pkg::S_IDLE;
        endcase
        if (i_restart) begin
            n_state = spm_pkg::S_BASE;
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = {1'b0, i_cfg.m};
        case (r_state)
            spm_pkg::S_CLIP: begin
                div_start    = 1'b1;
                div_dividend = spm_pkg::DIV_W'(numc_c[spm_pkg::DEN_W-1:7]);
            end
            spm_pkg::S_QR_GO, spm_pkg::S_QL_GO: begin
                div_start    = 1'b1;
                div_dividend = y_c[spm_pkg::IPROD_W-1:7];
            end
            spm_pkg::S_CR_GO: begin
                div_start    = 1'b1;
                div_dividend = r_g_r;
                div_divisor  = i_cfg.n;
            end
            spm_pkg::S_CL_GO: begin
                div_start    = 1'b1;
                div_dividend = r_g_l;
                div_divisor  = i_cfg.n;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase

        o_busy           = (r_state != spm_pkg::S_IDLE);
        o_wr.en          = (r_state == spm_pkg::S_WRITE);
        o_wr.addr        = r_ch;
        // gains of 0.0001 or less are dropped
        o_wr.gains.gl    = (r_g_l <= spm_pkg::GAIN_BITS'(spm_pkg::GAIN_ZERO_MAX)) ? '0 : r_g_l;
        o_wr.gains.gr    = (r_g_r <= spm_pkg::GAIN_BITS'(spm_pkg::GAIN_ZERO_MAX)) ? '0 : r_g_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::S_BASE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == spm_pkg::S_BASE) begin
                r_ch <= '0;
            end else if (r_state == spm_pkg::S_WRITE) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            spm_pkg::S_BASE: r_num <= base;
            spm_pkg::S_CLIP: r_numc <= numc_c;
            spm_pkg::S_SEG_WAIT: begin
                if (div_done) begin
                    r_seg_r <= div_quot[spm_pkg::SEG_W-1:0];
                    r_rr    <= rr_c;
                    // mirror position for the left gain
                    if (rr_c == '0) begin
                        r_seg_l <= spm_pkg::SEG_W'(spm_pkg::TBL_SEGS)
                                 - div_quot[spm_pkg::SEG_W-1:0];
                        r_rl    <= '0;
                    end else begin
                        r_seg_l <= spm_pkg::SEG_W'(spm_pkg::TBL_SEGS - 1)
                                 - div_quot[spm_pkg::SEG_W-1:0];
                        r_rl    <= span_c - rr_c;
                    end
                end
            end
            spm_pkg::S_MUL_R: begin
                r_prod <= spm_pkg::IPROD_W'(spm_pkg::sine_step(r_seg_r))
                        * spm_pkg::IPROD_W'(r_rr);
            end
            spm_pkg::S_QR_WAIT: begin
                if (div_done) r_g_r <= spm_pkg::sine_q15(r_seg_r) + div_quot;
            end
            spm_pkg::S_MUL_L: begin
                r_prod <= spm_pkg::IPROD_W'(spm_pkg::sine_step(r_seg_l))
                        * spm_pkg::IPROD_W'(r_rl);
            end
            spm_pkg::S_QL_WAIT: begin
                if (div_done) r_g_l <= spm_pkg::sine_q15(r_seg_l) + div_quot;
            end
            spm_pkg::S_CR_WAIT: if (div_done) r_g_r <= div_quot;
            spm_pkg::S_CL_WAIT: if (div_done) r_g_l <= div_quot;
            spm_pkg::S_WRITE: begin
                r_num <= r_num + $signed({6'b0, i_cfg.spr, 1'b0});
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/spm_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_mix
// Gain memory, multiply-accumulate of incoming words, and the output stage
// that rounds, saturates and holds the stereo result word.
// ----------------------------------------------------------------------------
module spm_mix (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  spm_pkg::t_cfg                         i_cfg,
    input  logic                                  i_hold,
    input  spm_pkg::t_gain_wr                     i_wr,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [spm_pkg::CH_W-1:0]              i_channel,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [spm_pkg::SAMPLE_BITS-1:0] o_left_sample,
    output logic signed [spm_pkg::SAMPLE_BITS-1:0] o_right_sample
);

    localparam logic signed [spm_pkg::ACC_W-1:0] HALF =
        spm_pkg::ACC_W'(64'sd1 <<< (spm_pkg::GAIN_FRAC - 1));
    localparam logic signed [spm_pkg::ACC_W-1:0] SAT_HI =
        spm_pkg::ACC_W'((64'sd1 <<< (spm_pkg::SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [spm_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 64'sd1;

    spm_pkg::t_gain_pair gain_mem [spm_pkg::MAX_CHANNELS];
    spm_pkg::t_gain_pair r_rd;

    spm_pkg::t_mix_state r_state;
    spm_pkg::t_mix_state n_state;

    logic signed [spm_pkg::SAMPLE_BITS-1:0] r_sample;
    logic                                   r_last;
    logic signed [spm_pkg::PROD_W-1:0]      r_prod_l;
    logic signed [spm_pkg::PROD_W-1:0]      r_prod_r;
    logic signed [spm_pkg::ACC_W-1:0]       r_acc_l;
    logic signed [spm_pkg::ACC_W-1:0]       r_acc_r;
    logic signed [spm_pkg::ACC_W-1:0]       r_sum_l;
    logic signed [spm_pkg::ACC_W-1:0]       r_sum_r;
    logic                                   r_out_valid;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] r_out_l;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] r_out_r;

    logic                                   accept;
    logic                                   ch_live;
    logic                                   out_load;
    logic signed [spm_pkg::ACC_W-1:0]       q_l;
    logic signed [spm_pkg::ACC_W-1:0]       q_r;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] sat_l;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] sat_r;

    // gain memory: written by the gain sweep, read on accept
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            gain_mem[i_wr.addr] <= i_wr.gains;
        end
        if (accept) begin
            r_rd <= gain_mem[i_channel];
        end
    end

    always_comb begin
        ch_live = ({1'b0, i_channel} < i_cfg.n);
        n_state = r_state;
        case (r_state)
            spm_pkg::MX_IDLE: if (accept && ch_live) n_state = spm_pkg::MX_MUL;
            spm_pkg::MX_MUL:  n_state = spm_pkg::MX_ACC;
            spm_pkg::MX_ACC:  n_state = r_last ? spm_pkg::MX_OUT : spm_pkg::MX_IDLE;
            spm_pkg::MX_OUT:  if (out_load) n_state = spm_pkg::MX_IDLE;
            default:          n_state = spm_pkg::MX_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == spm_pkg::MX_IDLE) && !i_hold;
        accept     = i_in_valid && o_in_ready;
        out_load   = (r_state == spm_pkg::MX_OUT) && (!r_out_valid || i_out_ready);
    end

    // floor((acc + half) / 2^15), then clamp to the sample range
    always_comb begin
        q_l = (r_sum_l + HALF) >>> spm_pkg::GAIN_FRAC;
        q_r = (r_sum_r + HALF) >>> spm_pkg::GAIN_FRAC;
        if (q_l > SAT_HI)      sat_l = SAT_HI[spm_pkg::SAMPLE_BITS-1:0];
        else if (q_l < SAT_LO) sat_l = SAT_LO[spm_pkg::SAMPLE_BITS-1:0];
        else                   sat_l = q_l[spm_pkg::SAMPLE_BITS-1:0];
        if (q_r > SAT_HI)      sat_r = SAT_HI[spm_pkg::SAMPLE_BITS-1:0];
        else if (q_r < SAT_LO) sat_r = SAT_LO[spm_pkg::SAMPLE_BITS-1:0];
        else                   sat_r = q_r[spm_pkg::SAMPLE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spm_pkg::MX_IDLE;
            r_out_valid <= 1'b0;
            r_acc_l     <= '0;
            r_acc_r     <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == spm_pkg::MX_ACC) begin
                if (r_last) begin
                    r_acc_l <= '0;
                    r_acc_r <= '0;
                end else begin
                    r_acc_l <= r_acc_l + spm_pkg::ACC_W'(r_prod_l);
                    r_acc_r <= r_acc_r + spm_pkg::ACC_W'(r_prod_r);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_last   <= ({1'b0, i_channel} == {1'b0, i_cfg.m});
        end
        if (r_state == spm_pkg::MX_MUL) begin
            r_prod_l <= r_sample * $signed({1'b0, r_rd.gl});
            r_prod_r <= r_sample * $signed({1'b0, r_rd.gr});
        end
        if (r_state == spm_pkg::MX_ACC) begin
            r_sum_l <= r_acc_l + spm_pkg::ACC_W'(r_prod_l);
            r_sum_r <= r_acc_r + spm_pkg::ACC_W'(r_prod_r);
        end
        if (out_load) begin
            r_out_l <= sat_l;
            r_out_r <= sat_r;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_out_l;
    assign o_right_sample = r_out_r;

endmodule

FILE: rtl/core/spread_pan_mixdown.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spread_pan_mixdown
// Equal-power stereo spread mixer: N mono channels to one saturated L/R pair.
// ----------------------------------------------------------------------------
// Words are taken one at a time, each through accept (gain read), multiply and
// accumulate; the last channel of a frame then registers its result in an output
// state once the output is free. The per-channel gains live in a 16-entry memory
// filled by a sweep through one serial divider, longer with compensation on.
// Reset loads the register defaults, clears the sums and starts that sweep;
// every config write restarts it. Input ready stays low while it runs.
module spread_pan_mixdown (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [spm_pkg::CH_W-1:0]               i_channel,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [spm_pkg::SAMPLE_BITS-1:0] o_left_sample,
    output logic signed [spm_pkg::SAMPLE_BITS-1:0] o_right_sample,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [spm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    logic [spm_pkg::NCH_W-1:0]        r_num_channels;
    logic signed [spm_pkg::POS_W-1:0] r_center;
    logic [spm_pkg::POS_W-1:0]        r_spread;
    logic                             r_compensate;

    logic                             cfg_we;
    spm_pkg::t_cfg                    cfg;
    spm_pkg::t_gain_wr                gain_wr;
    logic                             gc_busy;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= spm_pkg::NCH_W'(2);
            r_center       <= '0;
            r_spread       <= spm_pkg::POS_W'(1024);
            r_compensate   <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                spm_pkg::REG_NUM_CHANNELS: r_num_channels <= i_cfg_data[spm_pkg::NCH_W-1:0];
                spm_pkg::REG_CENTER:       r_center       <= i_cfg_data[spm_pkg::POS_W-1:0];
                spm_pkg::REG_SPREAD:       r_spread       <= i_cfg_data[spm_pkg::POS_W-1:0];
                spm_pkg::REG_COMPENSATE:   r_compensate   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // clamp registers to their legal ranges
    always_comb begin
        if (r_num_channels < spm_pkg::NCH_W'(2)) begin
            cfg.n = spm_pkg::NCH_W'(2);
        end else if (r_num_channels > spm_pkg::NCH_W'(spm_pkg::MAX_CHANNELS)) begin
            cfg.n = spm_pkg::NCH_W'(spm_pkg::MAX_CHANNELS);
        end else begin
            cfg.n = r_num_channels;
        end
        cfg.m = spm_pkg::CH_W'(cfg.n - 1'b1);
        if (r_center < -spm_pkg::POS_W'(512)) begin
            cfg.ctr = -spm_pkg::POS_W'(512);
        end else if (r_center > spm_pkg::POS_W'(512)) begin
            cfg.ctr = spm_pkg::POS_W'(512);
        end else begin
            cfg.ctr = r_center;
        end
        cfg.spr  = (r_spread > spm_pkg::POS_W'(1024)) ? spm_pkg::POS_W'(1024) : r_spread;
        cfg.comp = r_compensate;
    end

    spm_gain_calc u_gain_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_we),
        .i_cfg     (cfg),
        .o_wr      (gain_wr),
        .o_busy    (gc_busy)
    );

    spm_mix u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_hold         (gc_busy),
        .i_wr           (gain_wr),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_channel      (i_channel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample)
    );

    a_no_accept_during_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !gc_busy)
        else $error("word accepted while gain sweep runs");

    a_cfg_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_we |=> gc_busy)
        else $error("config write did not restart gain sweep");

    a_gain_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gain_wr.en |-> ({1'b0, gain_wr.addr} < cfg.n))
        else $error("gain written beyond channel count");

endmodule
